### rtl/assert_macros.svh
// Assertion macros for the RTL; the top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define AST_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define AST_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define AST_NOW(lbl, ante, cons)
`define AST_NEXT(lbl, ante, cons)
`endif
`endif

### rtl/fspb_pkg.sv
// Types and constants of the flow sticky port balancer.
package fspb_pkg;
    localparam int MAX_PORTS = 16;
    localparam int FLOW_ENTRIES = 1024;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_PORT_COUNT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOAD_AWARE = 4'd1;
    localparam logic [4:0] PORT_COUNT_RST = 5'd16;
    localparam logic [31:0] LOAD_MAX = 32'hffff_ffff;

    typedef struct packed {
        logic [31:0] src_addr;
        logic [15:0] src_l4_port;
        logic [31:0] dst_addr;
        logic [15:0] dst_l4_port;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  out_port;
        logic        is_new_flow;
        logic        table_full;
        logic [10:0] flow_total;
    } t_out_item;

    typedef struct packed {
        logic valid;
        logic pop;
    } t_q_ctrl;

    typedef struct packed {
        logic idle;
        logic at_capacity;
    } t_bk_status;
endpackage

### rtl/fspb_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
module fspb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/fspb_front.sv
// Front end: two-entry queue that accepts flow keys.
module fspb_front import fspb_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_item i_in_data,
    input  logic     i_pop,
    output t_q_ctrl  o_ctrl,
    output t_in_item o_item
);
    t_in_item   r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_in_stall = (r_cnt == 2'd2);
    assign push = i_in_valid && !o_in_stall;
    assign pop = i_pop && (r_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= !r_wp;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
        if (push) begin
            r_mem[r_wp] <= i_in_data;
        end
    end

    assign o_ctrl.valid = (r_cnt != 2'd0);
    assign o_ctrl.pop = pop;
    assign o_item = r_mem[r_rp];
endmodule

### rtl/fspb_back.sv
// Back end: flow table search, port choice, insert and result register.
module fspb_back import fspb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [4:0] i_port_count,
    input  logic       i_load_aware,
    input  t_q_ctrl    i_q,
    input  t_in_item   i_item,
    output logic       o_pop,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out_data,
    output t_bk_status o_status
);
    localparam int PW = (MAX_PORTS > 1) ? $clog2(MAX_PORTS) : 1;
    localparam int NW = ($clog2(MAX_PORTS + 1) > 5) ? $clog2(MAX_PORTS + 1) : 5;
    localparam int AW = $clog2(FLOW_ENTRIES);
    localparam int CW = AW + 1;
    localparam int KW = $bits(t_in_item);
    localparam int RW = KW + 4;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_CMP    = 6'b000010,
        S_MOD    = 6'b000100,
        S_SCAN   = 6'b001000,
        S_COMMIT = 6'b010000,
        S_OUT    = 6'b100000
    } t_state;

    t_state          r_state;
    t_in_item        r_key;
    logic [AW-1:0]   r_idx;
    logic [CW-1:0]   r_stored;
    logic [PW-1:0]   r_ptr, r_base, r_scan_idx, r_best;
    logic [NW-1:0]   r_scan_cnt;
    logic [31:0]     r_best_load;
    logic [31:0]     r_loads [MAX_PORTS];
    t_out_item       r_res, r_out;
    logic            r_ovalid;

    logic [NW-1:0]   n_active, pc_ext, base_ext, base_inc, scan_inc, cnt_inc;
    logic [CW-1:0]   idx_inc;
    logic [AW-1:0]   rd_addr;
    logic [RW-1:0]   rd_data, wr_data;
    logic            we, can_store;
    logic [31:0]     scan_load;

    assign pc_ext = NW'(i_port_count);
    always_comb begin
        if (pc_ext == '0) begin
            n_active = NW'(1);
        end else if (pc_ext > NW'(MAX_PORTS)) begin
            n_active = NW'(MAX_PORTS);
        end else begin
            n_active = pc_ext;
        end
    end

    assign base_ext = NW'(r_base);
    assign base_inc = base_ext + NW'(1);
    assign scan_inc = NW'(r_scan_idx) + NW'(1);
    assign cnt_inc = r_scan_cnt + NW'(1);
    assign idx_inc = CW'(r_idx) + CW'(1);
    assign scan_load = r_loads[r_scan_idx];
    assign can_store = (r_stored < CW'(FLOW_ENTRIES));

    assign rd_addr = (r_state == S_CMP) ? idx_inc[AW-1:0] : '0;
    assign we = (r_state == S_COMMIT) && can_store;
    assign wr_data = {r_key, 4'(r_best)};

    fspb_ram #(.WIDTH(RW), .DEPTH(FLOW_ENTRIES)) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_stored[AW-1:0]),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    assign o_pop = (r_state == S_IDLE) && i_q.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_stored <= '0;
            r_ptr <= '0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < MAX_PORTS; i++) begin
                r_loads[i] <= '0;
            end
        end else begin
            if (r_ovalid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q.valid) begin
                        r_key <= i_item;
                        r_idx <= '0;
                        r_base <= r_ptr;
                        r_state <= (r_stored == '0) ? S_MOD : S_CMP;
                    end
                end
                S_CMP: begin
                    if (rd_data[RW-1:4] == r_key) begin
                        r_res <= '{out_port: rd_data[3:0], is_new_flow: 1'b0,
                                   table_full: 1'b0, flow_total: 11'(r_stored)};
                        r_state <= S_OUT;
                    end else if (idx_inc == r_stored) begin
                        r_state <= S_MOD;
                    end else begin
                        r_idx <= idx_inc[AW-1:0];
                    end
                end
                S_MOD: begin
                    // reduce the pointer below the port count
                    if (base_ext >= n_active) begin
                        r_base <= PW'(base_ext - n_active);
                    end else if (i_load_aware) begin
                        r_scan_idx <= r_base;
                        r_scan_cnt <= '0;
                        r_state <= S_SCAN;
                    end else begin
                        r_best <= (base_inc == n_active) ? '0 : PW'(base_inc);
                        r_state <= S_COMMIT;
                    end
                end
                S_SCAN: begin
                    if (r_scan_cnt == '0 || scan_load < r_best_load) begin
                        r_best <= r_scan_idx;
                        r_best_load <= scan_load;
                    end
                    r_scan_idx <= (scan_inc == n_active) ? '0 : PW'(scan_inc);
                    r_scan_cnt <= cnt_inc;
                    if (cnt_inc == n_active) begin
                        r_state <= S_COMMIT;
                    end
                end
                S_COMMIT: begin
                    r_ptr <= r_best;
                    if (i_load_aware && r_loads[r_best] != LOAD_MAX) begin
                        r_loads[r_best] <= r_loads[r_best] + 32'd1;
                    end
                    if (can_store) begin
                        r_stored <= r_stored + CW'(1);
                    end
                    r_res <= '{out_port: 4'(r_best), is_new_flow: 1'b1,
                               table_full: !can_store,
                               flow_total: can_store ? 11'(r_stored + CW'(1))
                                                     : 11'(r_stored)};
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid) begin
                        r_ovalid <= 1'b1;
                        r_out <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data = r_out;
    assign o_status.idle = (r_state == S_IDLE);
    assign o_status.at_capacity = !can_store;
endmodule

### rtl/flow_sticky_port_balancer.sv
// Top level of the flow sticky port balancer.
// A known flow is searched entry by entry until the hit, then its result is registered;
// a new flow misses every stored entry, wraps the pointer below the port count, scans the
// port loads in load-aware mode, commits and registers its result. The flow table RAM is read one entry a cycle.
// Throughput: one transaction at a time in the back end; a two-entry queue absorbs input.
// Reset (synchronous, active low) empties the table, queue and result, zeroes loads.
`include "assert_macros.svh"
module flow_sticky_port_balancer import fspb_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    logic [4:0] r_port_count;
    logic       r_load_aware;
    t_q_ctrl    q_ctrl;
    t_in_item   q_item;
    t_bk_status bk_status;
    logic       bk_pop;

    // configuration: always ready, writes land at once; send them only while the block is empty
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_port_count <= PORT_COUNT_RST;
            r_load_aware <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_PORT_COUNT: r_port_count <= i_cfg_data[4:0];
                REG_LOAD_AWARE: r_load_aware <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // front: hold incoming transactions until the back end is free
    fspb_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_pop      (bk_pop),
        .o_ctrl     (q_ctrl),
        .o_item     (q_item)
    );

    // back: search the table, choose a port, insert, register the result
    fspb_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_port_count (r_port_count),
        .i_load_aware (r_load_aware),
        .i_q          (q_ctrl),
        .i_item       (q_item),
        .o_pop        (bk_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_data   (o_out_data),
        .o_status     (bk_status)
    );

    `AST_NOW(a_full_only_at_capacity, o_out_valid && o_out_data.table_full, bk_status.at_capacity)
    `AST_NOW(a_pop_only_when_idle, q_ctrl.pop, bk_status.idle)
    `AST_NOW(a_known_flow_not_full, o_out_valid && !o_out_data.is_new_flow, !o_out_data.table_full)
endmodule
